@@ hdl/ste_pkg.sv @@
`timescale 1ns / 1ps

package ste_pkg;

    localparam int COORD_WIDTH = 21;
    localparam int FRAC_BITS   = 10;

    // one point: x, y, z packed from the low end
    localparam int POINT_W = 63;

    // exact growth through the datapath
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PROD1_W = 2 * DIFF_W;
    localparam int CROSS_W = PROD1_W + 1;
    localparam int PROD2_W = DIFF_W + CROSS_W;
    localparam int DOT_W   = PROD2_W + 2;
    localparam int SUM_W   = DOT_W + 1;

    // register file
    localparam int EPS_W  = 40;
    localparam int DATA_W = 64;
    localparam int IDX_W  = 1;
    localparam int ADDR_W = IDX_W + 3;

    localparam logic [IDX_W-1:0] REG_DET_EPSILON = IDX_W'(0);

    // about 1e-5 in units of 2^-(3*FRAC_BITS)
    localparam logic [EPS_W-1:0] EPS_RESET =
        EPS_W'((64'd1 << (3 * FRAC_BITS)) / 64'd100000);

    function automatic logic signed [COORD_WIDTH-1:0] coord_of(
        input logic [POINT_W-1:0] pt,
        input int                 axis
    );
        return $signed(pt[axis*COORD_WIDTH +: COORD_WIDTH]);
    endfunction

    function automatic logic signed [DIFF_W-1:0] coord_diff(
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b
    );
        return DIFF_W'(a) - DIFF_W'(b);
    endfunction

endpackage

@@ hdl/ste_cfg.sv @@
`timescale 1ns / 1ps

module ste_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ste_pkg::ADDR_W-1:0]   paddr,
    input  logic [ste_pkg::DATA_W-1:0]   pwdata,
    output logic [ste_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output logic [ste_pkg::EPS_W-1:0]    o_eps
);

    logic [ste_pkg::EPS_W-1:0]  r_eps;
    logic [ste_pkg::IDX_W-1:0]  w_idx;
    logic                       w_wr;

    assign w_idx  = paddr[ste_pkg::ADDR_W-1:3];
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready
                    && (w_idx == ste_pkg::REG_DET_EPSILON);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= ste_pkg::EPS_RESET;
        end else if (w_wr) begin
            r_eps <= pwdata[ste_pkg::EPS_W-1:0];
        end
    end

    always_comb begin
        if (w_idx == ste_pkg::REG_DET_EPSILON) begin
            prdata = ste_pkg::DATA_W'(r_eps);
        end else begin
            prdata = '0;
        end
    end

    assign o_eps = r_eps;

endmodule

@@ hdl/ste_geom.sv @@
`timescale 1ns / 1ps

module ste_geom (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [ste_pkg::POINT_W-1:0]         i_seg_start,
    input  logic [ste_pkg::POINT_W-1:0]         i_seg_end,
    input  logic [ste_pkg::POINT_W-1:0]         i_vertex_a,
    input  logic [ste_pkg::POINT_W-1:0]         i_vertex_b,
    input  logic [ste_pkg::POINT_W-1:0]         i_vertex_c,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [ste_pkg::DIFF_W-1:0]   o_dir [3],
    output logic signed [ste_pkg::DIFF_W-1:0]   o_e1 [3],
    output logic signed [ste_pkg::DIFF_W-1:0]   o_e2 [3],
    output logic signed [ste_pkg::DIFF_W-1:0]   o_s [3],
    output logic signed [ste_pkg::CROSS_W-1:0]  o_h [3],
    output logic signed [ste_pkg::CROSS_W-1:0]  o_q [3]
);

    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3;

    // stage 1: edge and direction vectors
    logic signed [ste_pkg::DIFF_W-1:0] n_dir [3], n_e1 [3], n_e2 [3], n_s [3];
    logic signed [ste_pkg::DIFF_W-1:0] r1_dir [3], r1_e1 [3], r1_e2 [3], r1_s [3];
    // stage 2: cross product terms
    logic signed [ste_pkg::PROD1_W-1:0] n_ha [3], n_hb [3], n_qa [3], n_qb [3];
    logic signed [ste_pkg::PROD1_W-1:0] r2_ha [3], r2_hb [3], r2_qa [3], r2_qb [3];
    logic signed [ste_pkg::DIFF_W-1:0]  r2_dir [3], r2_e1 [3], r2_e2 [3], r2_s [3];
    // stage 3: h = dir x e2, q = s x e1
    logic signed [ste_pkg::CROSS_W-1:0] n_h [3], n_q [3];
    logic signed [ste_pkg::CROSS_W-1:0] r3_h [3], r3_q [3];
    logic signed [ste_pkg::DIFF_W-1:0]  r3_dir [3], r3_e1 [3], r3_e2 [3], r3_s [3];

    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v3;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_dir[i] = ste_pkg::coord_diff(ste_pkg::coord_of(i_seg_end, i),
                                           ste_pkg::coord_of(i_seg_start, i));
            n_e1[i]  = ste_pkg::coord_diff(ste_pkg::coord_of(i_vertex_b, i),
                                           ste_pkg::coord_of(i_vertex_a, i));
            n_e2[i]  = ste_pkg::coord_diff(ste_pkg::coord_of(i_vertex_c, i),
                                           ste_pkg::coord_of(i_vertex_a, i));
            n_s[i]   = ste_pkg::coord_diff(ste_pkg::coord_of(i_seg_start, i),
                                           ste_pkg::coord_of(i_vertex_a, i));
        end
    end

    always_comb begin
        n_ha[0] = ste_pkg::PROD1_W'(r1_dir[1]) * ste_pkg::PROD1_W'(r1_e2[2]);
        n_hb[0] = ste_pkg::PROD1_W'(r1_dir[2]) * ste_pkg::PROD1_W'(r1_e2[1]);
        n_ha[1] = ste_pkg::PROD1_W'(r1_dir[2]) * ste_pkg::PROD1_W'(r1_e2[0]);
        n_hb[1] = ste_pkg::PROD1_W'(r1_dir[0]) * ste_pkg::PROD1_W'(r1_e2[2]);
        n_ha[2] = ste_pkg::PROD1_W'(r1_dir[0]) * ste_pkg::PROD1_W'(r1_e2[1]);
        n_hb[2] = ste_pkg::PROD1_W'(r1_dir[1]) * ste_pkg::PROD1_W'(r1_e2[0]);
        n_qa[0] = ste_pkg::PROD1_W'(r1_s[1]) * ste_pkg::PROD1_W'(r1_e1[2]);
        n_qb[0] = ste_pkg::PROD1_W'(r1_s[2]) * ste_pkg::PROD1_W'(r1_e1[1]);
        n_qa[1] = ste_pkg::PROD1_W'(r1_s[2]) * ste_pkg::PROD1_W'(r1_e1[0]);
        n_qb[1] = ste_pkg::PROD1_W'(r1_s[0]) * ste_pkg::PROD1_W'(r1_e1[2]);
        n_qa[2] = ste_pkg::PROD1_W'(r1_s[0]) * ste_pkg::PROD1_W'(r1_e1[1]);
        n_qb[2] = ste_pkg::PROD1_W'(r1_s[1]) * ste_pkg::PROD1_W'(r1_e1[0]);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_h[i] = ste_pkg::CROSS_W'(r2_ha[i]) - ste_pkg::CROSS_W'(r2_hb[i]);
            n_q[i] = ste_pkg::CROSS_W'(r2_qa[i]) - ste_pkg::CROSS_W'(r2_qb[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (w_rdy1 && i_valid) begin
                r1_dir[i] <= n_dir[i];
                r1_e1[i]  <= n_e1[i];
                r1_e2[i]  <= n_e2[i];
                r1_s[i]   <= n_s[i];
            end
            if (w_rdy2 && r_v1) begin
                r2_ha[i]  <= n_ha[i];
                r2_hb[i]  <= n_hb[i];
                r2_qa[i]  <= n_qa[i];
                r2_qb[i]  <= n_qb[i];
                r2_dir[i] <= r1_dir[i];
                r2_e1[i]  <= r1_e1[i];
                r2_e2[i]  <= r1_e2[i];
                r2_s[i]   <= r1_s[i];
            end
            if (w_rdy3 && r_v2) begin
                r3_h[i]   <= n_h[i];
                r3_q[i]   <= n_q[i];
                r3_dir[i] <= r2_dir[i];
                r3_e1[i]  <= r2_e1[i];
                r3_e2[i]  <= r2_e2[i];
                r3_s[i]   <= r2_s[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_dir[i] = r3_dir[i];
            o_e1[i]  = r3_e1[i];
            o_e2[i]  = r3_e2[i];
            o_s[i]   = r3_s[i];
            o_h[i]   = r3_h[i];
            o_q[i]   = r3_q[i];
        end
    end

endmodule

@@ hdl/ste_dot.sv @@
`timescale 1ns / 1ps

module ste_dot (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [ste_pkg::DIFF_W-1:0]   i_dir [3],
    input  logic signed [ste_pkg::DIFF_W-1:0]   i_e1 [3],
    input  logic signed [ste_pkg::DIFF_W-1:0]   i_e2 [3],
    input  logic signed [ste_pkg::DIFF_W-1:0]   i_s [3],
    input  logic signed [ste_pkg::CROSS_W-1:0]  i_h [3],
    input  logic signed [ste_pkg::CROSS_W-1:0]  i_q [3],
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [ste_pkg::DOT_W-1:0]    o_det,
    output logic signed [ste_pkg::DOT_W-1:0]    o_nu,
    output logic signed [ste_pkg::DOT_W-1:0]    o_nv,
    output logic signed [ste_pkg::DOT_W-1:0]    o_nt
);

    logic r_v4, r_v5;
    logic w_rdy4, w_rdy5;

    logic signed [ste_pkg::PROD2_W-1:0] n_pdet [3], n_pnu [3], n_pnv [3], n_pnt [3];
    logic signed [ste_pkg::PROD2_W-1:0] r4_pdet [3], r4_pnu [3], r4_pnv [3], r4_pnt [3];
    logic signed [ste_pkg::DOT_W-1:0]   n_det, n_nu, n_nv, n_nt;
    logic signed [ste_pkg::DOT_W-1:0]   r5_det, r5_nu, r5_nv, r5_nt;

    assign w_rdy5  = !r_v5 || i_ready;
    assign w_rdy4  = !r_v4 || w_rdy5;
    assign o_ready = w_rdy4;
    assign o_valid = r_v5;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_pdet[i] = ste_pkg::PROD2_W'(i_e1[i])  * ste_pkg::PROD2_W'(i_h[i]);
            n_pnu[i]  = ste_pkg::PROD2_W'(i_s[i])   * ste_pkg::PROD2_W'(i_h[i]);
            n_pnv[i]  = ste_pkg::PROD2_W'(i_dir[i]) * ste_pkg::PROD2_W'(i_q[i]);
            n_pnt[i]  = ste_pkg::PROD2_W'(i_e2[i])  * ste_pkg::PROD2_W'(i_q[i]);
        end
    end

    always_comb begin
        n_det = ste_pkg::DOT_W'(r4_pdet[0]) + ste_pkg::DOT_W'(r4_pdet[1])
              + ste_pkg::DOT_W'(r4_pdet[2]);
        n_nu  = ste_pkg::DOT_W'(r4_pnu[0]) + ste_pkg::DOT_W'(r4_pnu[1])
              + ste_pkg::DOT_W'(r4_pnu[2]);
        n_nv  = ste_pkg::DOT_W'(r4_pnv[0]) + ste_pkg::DOT_W'(r4_pnv[1])
              + ste_pkg::DOT_W'(r4_pnv[2]);
        n_nt  = ste_pkg::DOT_W'(r4_pnt[0]) + ste_pkg::DOT_W'(r4_pnt[1])
              + ste_pkg::DOT_W'(r4_pnt[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy4) begin
                r_v4 <= i_valid;
            end
            if (w_rdy5) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4 && i_valid) begin
            for (int i = 0; i < 3; i++) begin
                r4_pdet[i] <= n_pdet[i];
                r4_pnu[i]  <= n_pnu[i];
                r4_pnv[i]  <= n_pnv[i];
                r4_pnt[i]  <= n_pnt[i];
            end
        end
        if (w_rdy5 && r_v4) begin
            r5_det <= n_det;
            r5_nu  <= n_nu;
            r5_nv  <= n_nv;
            r5_nt  <= n_nt;
        end
    end

    assign o_det = r5_det;
    assign o_nu  = r5_nu;
    assign o_nv  = r5_nv;
    assign o_nt  = r5_nt;

endmodule

@@ hdl/ste_decide.sv @@
`timescale 1ns / 1ps

module ste_decide (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [ste_pkg::DOT_W-1:0]    i_det,
    input  logic signed [ste_pkg::DOT_W-1:0]    i_nu,
    input  logic signed [ste_pkg::DOT_W-1:0]    i_nv,
    input  logic signed [ste_pkg::DOT_W-1:0]    i_nt,
    input  logic [ste_pkg::EPS_W-1:0]           i_eps,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_hit
);

    function automatic logic signed [ste_pkg::SUM_W-1:0] cond_neg(
        input logic                              neg,
        input logic signed [ste_pkg::SUM_W-1:0]  x
    );
        return neg ? -x : x;
    endfunction

    logic r_v6, r_v7, r_v8;
    logic w_rdy6, w_rdy7, w_rdy8;

    // stage 6: fold the determinant sign into every numerator
    logic                               n_neg, n_zero;
    logic signed [ste_pkg::SUM_W-1:0]   n_d, n_u, n_v, n_t, n_uvr;
    logic                               r6_neg, r6_zero;
    logic signed [ste_pkg::SUM_W-1:0]   r6_d, r6_u, r6_v, r6_t, r6_uvr;
    // stage 7: all tests but u + v <= det
    logic                               n_ok;
    logic signed [ste_pkg::SUM_W-1:0]   n_uv;
    logic                               r7_ok;
    logic signed [ste_pkg::SUM_W-1:0]   r7_d, r7_uv;
    // stage 8: result register
    logic                               n_hit;
    logic                               r8_hit;

    assign w_rdy8  = !r_v8 || i_ready;
    assign w_rdy7  = !r_v7 || w_rdy8;
    assign w_rdy6  = !r_v6 || w_rdy7;
    assign o_ready = w_rdy6;
    assign o_valid = r_v8;
    assign o_hit   = r8_hit;

    always_comb begin
        n_neg  = i_det[ste_pkg::DOT_W-1];
        n_zero = (i_det == '0);
        n_d    = cond_neg(n_neg, ste_pkg::SUM_W'(i_det));
        n_u    = cond_neg(n_neg, ste_pkg::SUM_W'(i_nu));
        n_v    = cond_neg(n_neg, ste_pkg::SUM_W'(i_nv));
        n_t    = cond_neg(n_neg, ste_pkg::SUM_W'(i_nt));
        n_uvr  = ste_pkg::SUM_W'(i_nu) + ste_pkg::SUM_W'(i_nv);
    end

    always_comb begin
        n_uv = cond_neg(r6_neg, r6_uvr);
        // d is non-negative here, so the epsilon test is unsigned
        n_ok = !r6_zero
            && ($unsigned(r6_d) >= ste_pkg::SUM_W'(i_eps))
            && !r6_u[ste_pkg::SUM_W-1] && (r6_u <= r6_d)
            && !r6_v[ste_pkg::SUM_W-1]
            && !r6_t[ste_pkg::SUM_W-1] && (r6_t <= r6_d);
    end

    assign n_hit = r7_ok && (r7_uv <= r7_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else begin
            if (w_rdy6) begin
                r_v6 <= i_valid;
            end
            if (w_rdy7) begin
                r_v7 <= r_v6;
            end
            if (w_rdy8) begin
                r_v8 <= r_v7;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy6 && i_valid) begin
            r6_neg  <= n_neg;
            r6_zero <= n_zero;
            r6_d    <= n_d;
            r6_u    <= n_u;
            r6_v    <= n_v;
            r6_t    <= n_t;
            r6_uvr  <= n_uvr;
        end
        if (w_rdy7 && r_v6) begin
            r7_ok <= n_ok;
            r7_d  <= r6_d;
            r7_uv <= n_uv;
        end
        if (w_rdy8 && r_v7) begin
            r8_hit <= n_hit;
        end
    end

endmodule

@@ hdl/segment_triangle_intersect.sv @@
`timescale 1ns / 1ps
// Channel   Handshake           Beat contents
// input     i_valid / o_ready   i_seg_start, i_seg_end, i_vertex_a, i_vertex_b, i_vertex_c
// output    o_valid / i_ready   o_hit
// config    psel/penable/pwrite det_epsilon at paddr 0 (64-bit data, 8-byte spacing)
//
// One beat in per cycle, one result out per cycle while i_ready is high; a beat passes
// the edge-vector stage, the two multiplier levels (cross products, then dot products)
// with their difference and sum stages, and the sign fold, compare and result stages.
// Synchronous active-low reset clears every stage valid and loads det_epsilon.
// Each stage takes a new beat when it is empty or its successor moves, so a
// stall fills the bubbles and then holds without dropping or repeating a beat.

module segment_triangle_intersect (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [ste_pkg::POINT_W-1:0]  i_seg_start,
    input  logic [ste_pkg::POINT_W-1:0]  i_seg_end,
    input  logic [ste_pkg::POINT_W-1:0]  i_vertex_a,
    input  logic [ste_pkg::POINT_W-1:0]  i_vertex_b,
    input  logic [ste_pkg::POINT_W-1:0]  i_vertex_c,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_hit,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ste_pkg::ADDR_W-1:0]   paddr,
    input  logic [ste_pkg::DATA_W-1:0]   pwdata,
    output logic [ste_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    logic [ste_pkg::EPS_W-1:0]          w_eps;

    logic                               w_geom_valid, w_dot_ready;
    logic signed [ste_pkg::DIFF_W-1:0]  w_dir [3], w_e1 [3], w_e2 [3], w_s [3];
    logic signed [ste_pkg::CROSS_W-1:0] w_h [3], w_q [3];

    logic                               w_dot_valid, w_dec_ready;
    logic signed [ste_pkg::DOT_W-1:0]   w_det, w_nu, w_nv, w_nt;

    ste_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_eps   (w_eps)
    );

    ste_geom u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_seg_start (i_seg_start),
        .i_seg_end   (i_seg_end),
        .i_vertex_a  (i_vertex_a),
        .i_vertex_b  (i_vertex_b),
        .i_vertex_c  (i_vertex_c),
        .o_valid     (w_geom_valid),
        .i_ready     (w_dot_ready),
        .o_dir       (w_dir),
        .o_e1        (w_e1),
        .o_e2        (w_e2),
        .o_s         (w_s),
        .o_h         (w_h),
        .o_q         (w_q)
    );

    ste_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_geom_valid),
        .o_ready (w_dot_ready),
        .i_dir   (w_dir),
        .i_e1    (w_e1),
        .i_e2    (w_e2),
        .i_s     (w_s),
        .i_h     (w_h),
        .i_q     (w_q),
        .o_valid (w_dot_valid),
        .i_ready (w_dec_ready),
        .o_det   (w_det),
        .o_nu    (w_nu),
        .o_nv    (w_nv),
        .o_nt    (w_nt)
    );

    ste_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dot_valid),
        .o_ready (w_dec_ready),
        .i_det   (w_det),
        .i_nu    (w_nu),
        .i_nv    (w_nv),
        .i_nt    (w_nt),
        .i_eps   (w_eps),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_hit   (o_hit)
    );

endmodule
